// ===== rtl/sdc_pkg.sv =====
`default_nettype none

package sdc_pkg;

    typedef logic [3:0] t_status;

    localparam t_status ST_OK          = 4'd0;
    localparam t_status ST_RESTART     = 4'd1;
    localparam t_status ST_BAD_START   = 4'd2;
    localparam t_status ST_BAD_TYPE    = 4'd3;
    localparam t_status ST_CRC         = 4'd4;
    localparam t_status ST_SECTION_HDR = 4'd5;
    localparam t_status ST_TRAILER     = 4'd6;
    localparam t_status ST_OVERFLOW    = 4'd7;
    localparam t_status ST_DONE        = 4'd8;
    localparam t_status ST_IGNORED     = 4'd9;

    typedef logic [1:0] t_model;

    localparam t_model MODEL_UNKNOWN = 2'd0;
    localparam t_model MODEL_C10     = 2'd1;
    localparam t_model MODEL_C81     = 2'd2;
    localparam t_model MODEL_C1      = 2'd3;

    localparam logic [7:0] MODEL_BYTE_C10 = 8'd10;
    localparam logic [7:0] MODEL_BYTE_C81 = 8'd81;
    localparam logic [7:0] MODEL_BYTE_C1  = 8'd1;

    typedef enum logic {
        CFG_LENIENT   = 1'b0,
        CFG_MAX_BYTES = 1'b1
    } t_cfg_index;

    localparam logic [15:0] CRC_POLY      = 16'h8005;
    localparam logic [7:0]  START_BYTE    = 8'h55;
    localparam logic [7:0]  TYPE_BYTE     = 8'd2;
    localparam logic [7:0]  TRAILER_BYTE  = 8'd7;
    localparam logic [15:0] PREAMBLE_LEN  = 16'd8;
    localparam logic [15:0] MAX_BYTES_RST = 16'd8192;
    localparam logic [15:0] SECTION_SPAN  = 16'd255;
    localparam logic [1:0]  HDR_LEN       = 2'd3;

    // Byte positions inside the preamble (count after the byte is taken)
    localparam logic [15:0] POS_START = 16'd1;
    localparam logic [15:0] POS_MODEL = 16'd2;
    localparam logic [15:0] POS_TYPE  = 16'd3;
    localparam logic [15:0] POS_COUNT = 16'd4;
    localparam logic [15:0] POS_LEN   = 16'd6;

    localparam int TDATA_W = 32;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        t_status     status;
        t_model      model_code;
        logic        halted;
    } t_result;

    // CRC-16, poly 0x8005, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/section_deframer_crc16.sv =====
`default_nettype none

// Section deframer with CRC-16 preamble check. Each input word is one received
// byte (tuser 0) or a line-error marker (tuser 1) that restarts the frame search;
// every input word gives exactly one output word carrying the byte if it is kept
// as frame data, its index among kept bytes, a status code, the current model
// code and the halt flag. The frame starts with an 8-byte preamble (0x55, model
// code, type 2, section count, two length bytes, two CRC bytes) whose CRC-16
// (poly 0x8005) must leave zero; then come 255-byte sections, each opened by a
// 3-byte header (0x55, sequence number, nonzero length), whose padding is
// dropped; the last frame byte must be trailer 7. In strict mode (lenient = 0)
// CRC and section-header errors and frame end halt the block, which then
// answers "ignored" until the next restart; in lenient mode those errors are
// only flagged. Overflow past max_bytes halts the block in either mode. One word
// is taken per clock while the output side keeps tready high: a word is held in
// the input register, the whole per-byte decode (CRC byte update, position
// compares and state update) is combinational, and the result waits in the
// output register. Configuration (register 0 lenient, register 1 max_bytes) is
// always ready and should be written only when idle.
module section_deframer_crc16 (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input words
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]             s_axis_tuser,   // [0] mode
    // Output words
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] data_byte, [23:8] data_index, [27:24] status, [29:28] model_code,
    // [30] halted, [31] zero
    output logic [sdc_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                  m_axis_tuser,   // [0] data_valid
    // Configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [0:0]             i_cfg_index,
    input  wire logic [15:0]            i_cfg_data
);
    import sdc_pkg::*;

    // Configuration registers
    logic        r_lenient;
    logic [15:0] r_max_bytes;

    // Input register
    logic        r_in_valid;
    logic        r_in_mode;
    logic [7:0]  r_in_byte;

    logic        w_step;
    logic        w_out_free;
    t_result     w_res;

    // Always take configuration words
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lenient   <= 1'b0;
            r_max_bytes <= MAX_BYTES_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LENIENT: begin
                    r_lenient <= i_cfg_data[0];
                end
                CFG_MAX_BYTES: begin
                    r_max_bytes <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the held word into the decoder whenever the output register
    // has room for its result
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload until the decoder takes it
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    sdc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_mode      (r_in_mode),
        .i_byte      (r_in_byte),
        .i_lenient   (r_lenient),
        .i_max_bytes (r_max_bytes),
        .o_res       (w_res)
    );

    sdc_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_step),
        .i_res         (w_res),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/sdc_core.sv =====
`default_nettype none

module sdc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic            i_mode,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_lenient,
    input  wire logic [15:0]     i_max_bytes,
    output sdc_pkg::t_result     o_res
);
    import sdc_pkg::*;

    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_kept_count, n_kept_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_start, n_start;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_sec_len, n_sec_len;
    logic [7:0]  r_sec_total, n_sec_total;
    logic [15:0] r_frame_len, n_frame_len;
    logic [7:0]  r_hdr [3];
    logic [7:0]  n_hdr [3];
    logic [1:0]  r_hdr_fill, n_hdr_fill;
    logic        r_in_padding, n_in_padding;
    t_model      r_model, n_model;
    logic        r_halt, n_halt;

    always_comb begin
        logic        restart;
        logic [15:0] size;
        logic [16:0] size_x;
        logic [15:0] crc_next;
        t_result     res;

        restart      = 1'b0;
        size         = r_byte_count + 16'd1;
        size_x       = {1'b0, size};
        crc_next     = crc16_byte(r_crc, i_byte);
        res          = '0;

        n_byte_count = r_byte_count;
        n_kept_count = r_kept_count;
        n_crc        = r_crc;
        n_start      = r_start;
        n_seq        = r_seq;
        n_sec_len    = r_sec_len;
        n_sec_total  = r_sec_total;
        n_frame_len  = r_frame_len;
        n_hdr        = r_hdr;
        n_hdr_fill   = r_hdr_fill;
        n_in_padding = r_in_padding;
        n_model      = r_model;
        n_halt       = r_halt;

        if (i_mode) begin
            restart    = 1'b1;
            res.status = ST_RESTART;
        end else if (r_halt) begin
            res.status = ST_IGNORED;
        end else if (r_byte_count >= i_max_bytes) begin
            res.status = ST_OVERFLOW;
            n_halt     = 1'b1;
        end else begin
            if (!r_in_padding) begin
                res.data_valid = 1'b1;
                res.data_byte  = i_byte;
                res.data_index = r_kept_count;
                n_kept_count   = r_kept_count + 16'd1;
            end
            n_byte_count = size;
            if (r_hdr_fill != HDR_LEN) begin
                n_hdr[r_hdr_fill] = i_byte;
                n_hdr_fill        = r_hdr_fill + 2'd1;
            end
            n_crc = crc_next;

            if (size == POS_START && i_byte != START_BYTE) begin
                restart    = 1'b1;
                res.status = ST_BAD_START;
            end else if (size == POS_TYPE && i_byte != TYPE_BYTE) begin
                restart    = 1'b1;
                res.status = ST_BAD_TYPE;
            end else begin
                if (size == POS_MODEL) begin
                    if (i_byte == MODEL_BYTE_C1) begin
                        n_model = MODEL_C1;
                    end else if (i_byte == MODEL_BYTE_C10) begin
                        n_model = MODEL_C10;
                    end else if (i_byte == MODEL_BYTE_C81) begin
                        n_model = MODEL_C81;
                    end
                end
                if (size == POS_COUNT) begin
                    n_sec_total = i_byte;
                end
                if (size == POS_LEN) begin
                    n_frame_len = PREAMBLE_LEN + 16'd1 + 16'(16'(r_sec_total) * SECTION_SPAN);
                end
                if (size == PREAMBLE_LEN && crc_next != 16'd0) begin
                    res.status = ST_CRC;
                    if (!i_lenient) begin
                        n_halt = 1'b1;
                    end
                end
                if (size >= PREAMBLE_LEN) begin
                    if (size == r_start) begin
                        n_hdr_fill = 2'd0;
                    end
                    if (size_x == {1'b0, r_start} + 17'd3) begin
                        if (n_hdr[0] != START_BYTE || n_hdr[1] != r_seq || n_hdr[2] == 8'd0)
                        begin
                            if (res.status == ST_OK) begin
                                res.status = ST_SECTION_HDR;
                            end
                            if (!i_lenient) begin
                                n_halt = 1'b1;
                            end
                        end
                        n_sec_len    = n_hdr[2];
                        n_in_padding = 1'b0;
                        n_crc        = 16'd0;
                    end
                    if (size_x >= {1'b0, r_start} + 17'd3 &&
                        size_x == {1'b0, r_start} + 17'(n_sec_len) + 17'd3) begin
                        n_start      = 16'(16'(r_seq) * SECTION_SPAN) + PREAMBLE_LEN;
                        n_seq        = r_seq + 8'd1;
                        n_in_padding = 1'b1;
                    end
                    if (size == n_frame_len) begin
                        if (i_byte != TRAILER_BYTE && res.status == ST_OK) begin
                            res.status = ST_TRAILER;
                        end
                        if (!i_lenient) begin
                            if (res.status == ST_OK) begin
                                res.status = ST_DONE;
                            end
                            n_halt = 1'b1;
                        end
                    end
                end
            end
        end

        // Frame restart keeps the model code and the section count
        if (restart) begin
            n_byte_count   = 16'd0;
            n_kept_count   = 16'd0;
            n_crc          = 16'd0;
            n_start        = PREAMBLE_LEN;
            n_seq          = 8'd1;
            n_sec_len      = 8'd0;
            n_frame_len    = 16'd0;
            n_hdr[0]       = 8'd0;
            n_hdr[1]       = 8'd0;
            n_hdr[2]       = 8'd0;
            n_hdr_fill     = 2'd0;
            n_in_padding   = 1'b0;
            n_halt         = 1'b0;
            res.data_valid = 1'b0;
            res.data_byte  = 8'd0;
            res.data_index = 16'd0;
        end

        res.model_code = n_model;
        res.halted     = n_halt;
        o_res          = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 16'd0;
            r_kept_count <= 16'd0;
            r_crc        <= 16'd0;
            r_start      <= PREAMBLE_LEN;
            r_seq        <= 8'd1;
            r_sec_len    <= 8'd0;
            r_sec_total  <= 8'd0;
            r_frame_len  <= 16'd0;
            r_hdr[0]     <= 8'd0;
            r_hdr[1]     <= 8'd0;
            r_hdr[2]     <= 8'd0;
            r_hdr_fill   <= 2'd0;
            r_in_padding <= 1'b0;
            r_model      <= MODEL_UNKNOWN;
            r_halt       <= 1'b0;
        end else if (i_step) begin
            r_byte_count <= n_byte_count;
            r_kept_count <= n_kept_count;
            r_crc        <= n_crc;
            r_start      <= n_start;
            r_seq        <= n_seq;
            r_sec_len    <= n_sec_len;
            r_sec_total  <= n_sec_total;
            r_frame_len  <= n_frame_len;
            r_hdr        <= n_hdr;
            r_hdr_fill   <= n_hdr_fill;
            r_in_padding <= n_in_padding;
            r_model      <= n_model;
            r_halt       <= n_halt;
        end
    end

    a_restart_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_mode) |=> (r_byte_count == 16'd0))
        else $error("byte count not cleared by restart");

    a_halted_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_mode && r_halt) |-> (o_res.status == ST_IGNORED && !o_res.data_valid))
        else $error("byte processed while halted");

    a_kept_le_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= r_byte_count)
        else $error("more kept bytes than received bytes");

endmodule

`default_nettype wire

// ===== rtl/sdc_out_reg.sv =====
`default_nettype none

module sdc_out_reg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  sdc_pkg::t_result                  i_res,
    output logic                              o_free,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [sdc_pkg::TDATA_W-1:0]       m_axis_tdata,
    output logic [0:0]                        m_axis_tuser
);
    import sdc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {1'b0, r_res.halted, r_res.model_code, r_res.status,
                            r_res.data_index, r_res.data_byte};
    assign m_axis_tuser  = r_res.data_valid;

endmodule

`default_nettype wire

// ===== verif/section_deframer_crc16_tb.sv =====
`timescale 1ns / 1ps

module section_deframer_crc16_tb;
    import sdc_pkg::*;

    // Input word kinds carried in s_axis_tuser
    localparam bit MODE_BYTE     = 1'b0;
    localparam bit MODE_LINE_ERR = 1'b1;

    localparam int CYCLE_LIMIT   = 400000;
    // Pipeline is two deep; let it settle before touching config or ending
    localparam int SETTLE_CYCLES = 8;

    // Ways to spoil an otherwise well-formed frame
    typedef enum {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_HDR,
        FAULT_TRAILER,
        FAULT_MODEL,
        FAULT_TRUNC,
        FAULT_TYPE
    } t_fault;

    // Tracks the deframer state word by word and holds the results still owed
    class deframe_tracker;
        bit          lenient;
        int unsigned max_bytes;

        int unsigned byte_count;
        int unsigned kept_count;
        logic [15:0] crc_reg;
        int unsigned sec_start;
        int unsigned sec_seq;
        int unsigned sec_len;
        int unsigned sec_total;
        int unsigned frame_len;
        logic [7:0]  hdr [3];
        int unsigned hdr_fill;
        bit          in_pad;
        t_model      model;
        bit          halt;

        t_result     pending_results [$];
        int          errors;

        // Bitwise CRC-16 shift, one input bit at a time
        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            bit fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0};
                if (fb) c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        // Line restart: drop frame progress, keep model and section count
        function void clear_frame();
            byte_count = 0;
            kept_count = 0;
            crc_reg    = '0;
            sec_start  = PREAMBLE_LEN;
            sec_seq    = 1;
            sec_len    = 0;
            frame_len  = 0;
            foreach (hdr[i]) hdr[i] = '0;
            hdr_fill   = 0;
            in_pad     = 1'b0;
            halt       = 1'b0;
        endfunction

        function void reset();
            lenient   = 1'b0;
            max_bytes = MAX_BYTES_RST;
            clear_frame();
            sec_total = 0;
            model     = MODEL_UNKNOWN;
            errors    = 0;
            pending_results.delete();
        endfunction

        function void set_reg(t_cfg_index idx, logic [15:0] value);
            if (idx == CFG_LENIENT) lenient = value[0];
            else max_bytes = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the state by one accepted word and queue the result it owes
        function t_status note_word(bit line_err, logic [7:0] b);
            t_result     r;
            int unsigned size;
            r = '0;
            if (line_err) begin
                clear_frame();
                r.status = ST_RESTART;
            end else if (halt) begin
                r.status = ST_IGNORED;
            end else if (byte_count >= max_bytes) begin
                r.status = ST_OVERFLOW;
                halt     = 1'b1;
            end else begin
                if (!in_pad) begin
                    r.data_valid = 1'b1;
                    r.data_byte  = b;
                    r.data_index = 16'(kept_count);
                    kept_count   = (kept_count + 1) & 32'hFFFF;
                end
                byte_count = (byte_count + 1) & 32'hFFFF;
                size       = byte_count;
                if (hdr_fill < 3) begin
                    hdr[hdr_fill] = b;
                    hdr_fill++;
                end
                crc_reg = crc_step(crc_reg, b);

                if (size == POS_START && b != START_BYTE) begin
                    clear_frame();
                    r        = '0;
                    r.status = ST_BAD_START;
                end else if (size == POS_TYPE && b != TYPE_BYTE) begin
                    clear_frame();
                    r        = '0;
                    r.status = ST_BAD_TYPE;
                end else begin
                    // unknown model bytes leave the last known model in place
                    if (size == POS_MODEL) begin
                        if (b == MODEL_BYTE_C1) model = MODEL_C1;
                        else if (b == MODEL_BYTE_C10) model = MODEL_C10;
                        else if (b == MODEL_BYTE_C81) model = MODEL_C81;
                    end
                    if (size == POS_COUNT) sec_total = b;
                    if (size == POS_LEN)
                        frame_len = (PREAMBLE_LEN + sec_total * SECTION_SPAN + 1) & 32'hFFFF;
                    if (size == PREAMBLE_LEN && crc_reg != 0) begin
                        r.status = ST_CRC;
                        if (!lenient) halt = 1'b1;
                    end
                    if (size >= PREAMBLE_LEN) begin
                        if (size == sec_start) hdr_fill = 0;
                        if (size == sec_start + HDR_LEN) begin
                            if (hdr[0] != START_BYTE || hdr[1] != sec_seq || hdr[2] == 0) begin
                                if (r.status == ST_OK) r.status = ST_SECTION_HDR;
                                if (!lenient) halt = 1'b1;
                            end
                            sec_len = hdr[2];
                            in_pad  = 1'b0;
                            crc_reg = '0;
                        end
                        if (size >= sec_start + HDR_LEN &&
                            size == sec_start + sec_len + HDR_LEN) begin
                            sec_start = (sec_seq * SECTION_SPAN + PREAMBLE_LEN) & 32'hFFFF;
                            sec_seq   = (sec_seq + 1) & 32'hFF;
                            in_pad    = 1'b1;
                        end
                        if (size == frame_len) begin
                            if (b != TRAILER_BYTE && r.status == ST_OK)
                                r.status = ST_TRAILER;
                            if (!lenient) begin
                                if (r.status == ST_OK) r.status = ST_DONE;
                                halt = 1'b1;
                            end
                        end
                    end
                end
            end
            r.model_code = model;
            r.halted     = halt;
            pending_results.push_back(r);
            return r.status;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [TDATA_W-1:0] tdata, logic tuser);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("output word with no result pending: tdata %h", tdata);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("data_valid", want.data_valid, tuser);
            compare_field("data_byte", want.data_byte, tdata[7:0]);
            compare_field("data_index", want.data_index, tdata[23:8]);
            compare_field("status", want.status, tdata[27:24]);
            compare_field("model_code", want.model_code, tdata[29:28]);
            compare_field("halted", want.halted, tdata[30]);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_index           i_cfg_index = CFG_LENIENT;
    logic [15:0]          i_cfg_data = '0;

    deframe_tracker       sb;
    logic [7:0]           frame_bytes [$];
    int                   sent_words = 0;   // accepted input words
    int                   cycles = 0;
    bit                   idle_on = 1'b1;   // random gaps and stalls allowed
    bit                   tx_quiet = 1'b0;  // sender holds off gaps for this sequence
    int                   rx_stall = 0;
    int                   rx_calm = 0;

    section_deframer_crc16 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop: no correct run gets anywhere near this
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output side backpressure: random stall bursts, with calm stretches between
    always @(negedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else if (rx_calm > 0) begin
            m_axis_tready <= 1'b1;
            rx_calm--;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    rx_stall = $urandom_range(0, 7);
                    m_axis_tready <= 1'b0;
                end
                1: begin
                    rx_calm = $urandom_range(20, 80);
                    m_axis_tready <= 1'b1;
                end
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Check every word that leaves the block against the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser[0]);
    end

    // Offer one word; called and returns at a falling edge. tvalid stays high on return.
    task automatic send_word(bit mode, logic [7:0] b);
        if (idle_on && !tx_quiet && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        void'(sb.note_word(mode == MODE_LINE_ERR, b));
        sent_words++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_word(MODE_BYTE, frame_bytes[i]);
    endtask

    // Drop tvalid and hold until every owed result has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_beat(t_cfg_index idx, logic [15:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
    endtask

    // Write both registers back to back once the block has gone quiet
    task automatic configure(bit lenient_v, logic [15:0] max_v);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        cfg_beat(CFG_LENIENT, {15'd0, lenient_v});
        cfg_beat(CFG_MAX_BYTES, max_v);
        i_cfg_valid <= 1'b0;
    endtask

    // Build a frame with n_sec sections into frame_bytes, spoiled as the fault says
    task automatic build_frame(int n_sec, t_fault fault);
        logic [7:0]  model_b;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [7:0]  h2;
        logic [15:0] c;
        int          len;
        int          pad;
        int          bad_sec;
        int          keep;
        int          idx;
        frame_bytes.delete();
        case ($urandom_range(0, 2))
            0: model_b = MODEL_BYTE_C1;
            1: model_b = MODEL_BYTE_C10;
            default: model_b = MODEL_BYTE_C81;
        endcase
        if (fault == FAULT_MODEL) begin
            do model_b = 8'($urandom);
            while (model_b == MODEL_BYTE_C1 || model_b == MODEL_BYTE_C10 ||
                   model_b == MODEL_BYTE_C81);
        end
        frame_bytes.push_back(START_BYTE);
        frame_bytes.push_back(model_b);
        frame_bytes.push_back(fault == FAULT_TYPE ? TYPE_BYTE ^ 8'($urandom_range(1, 255))
                                                  : TYPE_BYTE);
        frame_bytes.push_back(8'(n_sec));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        // Appending the CRC high byte first leaves a zero residue
        c = '0;
        foreach (frame_bytes[i]) c = sb.crc_step(c, frame_bytes[i]);
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
        if (fault == FAULT_CRC) begin
            idx = $urandom_range(4, 7);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
        end

        bad_sec = (fault == FAULT_HDR && n_sec > 0) ? $urandom_range(1, n_sec) : 0;
        for (int s = 1; s <= n_sec; s++) begin
            case ($urandom_range(0, 3))
                0: len = 1;
                1: len = SECTION_SPAN - HDR_LEN;    // section fully used, no padding
                default: len = $urandom_range(1, SECTION_SPAN - HDR_LEN);
            endcase
            pad = SECTION_SPAN - HDR_LEN - len;
            h0  = START_BYTE;
            h1  = 8'(s);
            h2  = 8'(len);
            if (s == bad_sec) begin
                case ($urandom_range(0, 2))
                    0: h0 = START_BYTE ^ 8'($urandom_range(1, 255));
                    1: h1 = 8'(s + 1);
                    default: h2 = 8'd0;
                endcase
            end
            frame_bytes.push_back(h0);
            frame_bytes.push_back(h1);
            frame_bytes.push_back(h2);
            repeat (len) frame_bytes.push_back(8'($urandom));
            repeat (pad) frame_bytes.push_back(8'($urandom));
        end
        frame_bytes.push_back(fault == FAULT_TRAILER ?
                              TRAILER_BYTE ^ 8'($urandom_range(1, 255)) : TRAILER_BYTE);

        if (fault == FAULT_TRUNC) begin
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
    endtask

    // Mostly frames with random content, some of them spoiled, the rest line noise
    task automatic run_phase(int quota);
        int     base;
        int     pick;
        int     n_sec;
        int     len;
        bit     mode;
        t_fault fault;
        logic [7:0] b;
        base = sent_words;
        while (sent_words - base < quota) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick  = $urandom_range(0, 99);
                n_sec = (pick < 90) ? 0 : (pick < 99) ? 1 : 2;
                case ($urandom_range(0, 9))
                    4: fault = FAULT_CRC;
                    5: fault = FAULT_HDR;
                    6: fault = FAULT_TRAILER;
                    7: fault = FAULT_MODEL;
                    8: fault = FAULT_TRUNC;
                    9: fault = FAULT_TYPE;
                    default: fault = FAULT_NONE;
                endcase
                build_frame(n_sec, fault);
                send_frame();
                // now and then skip the restart so the next frame lands on a halted block
                if ($urandom_range(0, 9) != 0) send_word(MODE_LINE_ERR, 8'($urandom));
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    mode = ($urandom_range(0, 7) == 0);
                    b    = 8'($urandom);
                    if (i == 0 && $urandom_range(0, 1) == 1) b = START_BYTE;
                    if (i == 2 && $urandom_range(0, 1) == 1) b = TYPE_BYTE;
                    send_word(mode, b);
                end
            end
        end
        tx_quiet = 1'b0;
    endtask

    initial begin
        sb = new();
        sb.reset();
        // Hold reset, release at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: restart, bad start bytes at both extremes, bad type,
        // a clean empty frame ending in done, a word on the halted block,
        // then a frame whose CRC fails in strict mode.
        send_word(MODE_LINE_ERR, 8'hFF);
        send_word(MODE_BYTE, 8'h00);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_BYTE, START_BYTE);
        send_word(MODE_BYTE, MODEL_BYTE_C10);
        send_word(MODE_BYTE, 8'h03);
        build_frame(0, FAULT_NONE);
        send_frame();
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_LINE_ERR, 8'h00);
        build_frame(0, FAULT_CRC);
        send_frame();
        send_word(MODE_LINE_ERR, 8'h00);

        // Random phases over several register settings, extremes included
        configure(1'b1, 16'hFFFF);
        run_phase(350);
        configure(1'b0, 16'd1);
        run_phase(120);
        configure(1'b1, 16'd300);
        run_phase(350);
        configure(1'b0, 16'hFFFF);
        run_phase(350);
        configure(1'b0, MAX_BYTES_RST);
        idle_on = 1'b0;
        run_phase(350);

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sdc_pkg.sv
rtl/sdc_core.sv
rtl/sdc_out_reg.sv
rtl/section_deframer_crc16.sv
verif/section_deframer_crc16_tb.sv
